>>> rtl/sfb_pkg.sv
// ----------------------------------------------------------------------------
// sfb_pkg: shared types and constants of the serial frame builder
// command format passed from front to back, frame constants, crc helper
// ----------------------------------------------------------------------------
`default_nettype none

package sfb_pkg;

    // input actions
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // frame kinds
    localparam logic [7:0] KIND_ATTN  = 8'd1;
    localparam logic [7:0] KIND_FIRST = 8'd2;
    localparam logic [7:0] KIND_CONT  = 8'd3;

    // attention frame bytes
    localparam logic [7:0] ATTN_BYTE0 = 8'h01;
    localparam logic [7:0] ATTN_BYTE1 = 8'hFE;

    // data frame overhead: kind, ~kind, seq, len hi, len lo, crc lo, crc hi
    localparam logic [16:0] DATA_OVERHEAD = 17'd7;
    localparam logic [16:0] ATTN_LEN      = 17'd2;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8408;

    localparam logic [7:0] PKT_TYPE_RESET = 8'd22;
    localparam int unsigned PKT_MAX_DEFAULT = 32;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        OP_ATTN,
        OP_DSTART,
        OP_PAYLOAD
    } t_op;

    // one command for the back end
    // val holds the kind on a start and the data byte on a payload
    typedef struct packed {
        t_op         op;
        logic [7:0]  val;
        logic [7:0]  seq;
        logic [15:0] len;
        logic        last;
    } t_cmd;

    // reflected crc-16 update over one byte
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/sfb_if.sv
// ----------------------------------------------------------------------------
// sfb_if: channel interfaces of the serial frame builder
// valid/ready channels for input items and line bytes
// ----------------------------------------------------------------------------
`default_nettype none

interface sfb_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  frame_kind;
    logic [7:0]  sequence_req;
    logic [15:0] payload_len;
    logic [7:0]  data_byte;

    modport source (
        output valid, action, frame_kind, sequence_req, payload_len, data_byte,
        input  ready
    );
    modport sink (
        input  valid, action, frame_kind, sequence_req, payload_len, data_byte,
        output ready
    );
endinterface

interface sfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_start;
    logic       frame_end;

    modport source (
        output valid, out_byte, packet_start, frame_end,
        input  ready
    );
    modport sink (
        input  valid, out_byte, packet_start, frame_end,
        output ready
    );
endinterface

`default_nettype wire

>>> rtl/sfb_front.sv
// ----------------------------------------------------------------------------
// sfb_front: input classifier
// accepts items, tracks open payload, pushes commands into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sfb_in_if.sink             i_in,
    input  wire logic          i_full,
    output logic               o_push,
    output sfb_pkg::t_cmd      o_cmd
);
    import sfb_pkg::*;

    logic [15:0] r_payload_left;
    logic [15:0] n_payload_left;
    logic        w_accept;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    always_comb begin
        n_payload_left = r_payload_left;
        o_push         = 1'b0;
        o_cmd.op       = OP_PAYLOAD;
        o_cmd.val      = i_in.data_byte;
        o_cmd.seq      = i_in.sequence_req;
        o_cmd.len      = i_in.payload_len;
        o_cmd.last     = (r_payload_left == 16'd1);
        if (w_accept) begin
            if (i_in.action == ACT_START) begin
                n_payload_left = '0;
                o_cmd.val      = i_in.frame_kind;
                unique case (i_in.frame_kind) inside
                    KIND_ATTN: begin
                        o_push   = 1'b1;
                        o_cmd.op = OP_ATTN;
                    end
                    KIND_FIRST, KIND_CONT: begin
                        o_push         = 1'b1;
                        o_cmd.op       = OP_DSTART;
                        n_payload_left = i_in.payload_len;
                    end
                    default: begin
                        // unknown kind: frame closed, nothing sent
                        o_push = 1'b0;
                    end
                endcase
            end else if (r_payload_left != '0) begin
                o_push         = 1'b1;
                n_payload_left = r_payload_left - 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_left <= '0;
        end else begin
            r_payload_left <= n_payload_left;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sfb_queue.sv
// ----------------------------------------------------------------------------
// sfb_queue: command queue
// small first-word-fall-through fifo between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire sfb_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_valid,
    output sfb_pkg::t_cmd      o_cmd
);
    import sfb_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/sfb_back.sv
// ----------------------------------------------------------------------------
// sfb_back: byte sequencer
// expands commands into frame bytes, packet headers and the crc tail
// ----------------------------------------------------------------------------
`default_nettype none

module sfb_back #(
    parameter int unsigned MAX_PACKET_BYTES = sfb_pkg::PKT_MAX_DEFAULT
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire sfb_pkg::t_cmd i_cmd,
    input  wire logic [7:0]    i_pkt_type,
    output logic               o_pop,
    sfb_out_if.source          o_out
);
    import sfb_pkg::*;

    // byte positions inside a command
    localparam logic [2:0] POS_KIND   = 3'd0;
    localparam logic [2:0] POS_NKIND  = 3'd1;
    localparam logic [2:0] POS_SEQ    = 3'd2;
    localparam logic [2:0] POS_LENHI  = 3'd3;
    localparam logic [2:0] POS_LENLO  = 3'd4;
    localparam logic [2:0] POS_DCRCLO = 3'd5;
    localparam logic [2:0] POS_DCRCHI = 3'd6;
    localparam logic [2:0] POS_DATA   = 3'd0;
    localparam logic [2:0] POS_PCRCLO = 3'd1;
    localparam logic [2:0] POS_PCRCHI = 3'd2;

    typedef enum logic [1:0] {
        HDR_TYPE,
        HDR_LEN,
        HDR_CHECK
    } t_hdr;

    t_hdr        r_hdr,       n_hdr;
    logic        r_busy,      n_busy;
    logic [2:0]  r_idx,       n_idx;
    logic [16:0] r_frame,     n_frame;
    logic [7:0]  r_pkt,       n_pkt;
    logic [15:0] r_crc,       n_crc;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_pstart,    n_pstart;
    logic        r_fend,      n_fend;

    logic        w_fresh;
    logic [16:0] w_frame;
    logic [7:0]  w_pkt;
    logic [15:0] w_crc;
    logic [15:0] w_fcs;
    logic [7:0]  w_hdr_len;
    logic [7:0]  w_byte;
    logic [2:0]  w_last_idx;
    logic        w_upd;
    logic        w_step;

    // a start command resets the frame state the first time it is worked on
    assign w_fresh = !r_busy && (i_cmd.op == OP_ATTN || i_cmd.op == OP_DSTART);
    assign w_frame = !w_fresh ? r_frame :
                     (i_cmd.op == OP_ATTN) ? ATTN_LEN : ({1'b0, i_cmd.len} + DATA_OVERHEAD);
    assign w_pkt   = w_fresh ? '0 : r_pkt;
    assign w_crc   = w_fresh ? CRC_INIT : r_crc;
    assign w_fcs   = ~w_crc;

    assign w_hdr_len = (w_frame > 17'(MAX_PACKET_BYTES)) ? 8'(MAX_PACKET_BYTES) : w_frame[7:0];

    always_comb begin
        w_byte     = '0;
        w_last_idx = '0;
        w_upd      = 1'b0;
        unique case (i_cmd.op)
            OP_ATTN: begin
                w_byte     = (r_idx == POS_KIND) ? ATTN_BYTE0 : ATTN_BYTE1;
                w_last_idx = POS_NKIND;
            end
            OP_DSTART: begin
                w_last_idx = (i_cmd.len == '0) ? POS_DCRCHI : POS_LENLO;
                w_upd      = (r_idx == POS_SEQ) || (r_idx == POS_LENHI) || (r_idx == POS_LENLO);
                case (r_idx)
                    POS_KIND:   w_byte = i_cmd.val;
                    POS_NKIND:  w_byte = ~i_cmd.val;
                    POS_SEQ:    w_byte = i_cmd.seq;
                    POS_LENHI:  w_byte = i_cmd.len[15:8];
                    POS_LENLO:  w_byte = i_cmd.len[7:0];
                    POS_DCRCLO: w_byte = w_fcs[7:0];
                    default:    w_byte = w_fcs[15:8];
                endcase
            end
            OP_PAYLOAD: begin
                w_last_idx = i_cmd.last ? POS_PCRCHI : POS_DATA;
                w_upd      = (r_idx == POS_DATA);
                case (r_idx)
                    POS_DATA:   w_byte = i_cmd.val;
                    POS_PCRCLO: w_byte = w_fcs[7:0];
                    default:    w_byte = w_fcs[15:8];
                endcase
            end
            default: begin
                w_byte = '0;
            end
        endcase
    end

    assign w_step = i_valid && (!r_out_valid || o_out.ready);

    always_comb begin
        n_hdr       = r_hdr;
        n_busy      = r_busy;
        n_idx       = r_idx;
        n_frame     = r_frame;
        n_pkt       = r_pkt;
        n_crc       = r_crc;
        n_out_valid = o_out.ready ? 1'b0 : r_out_valid;
        n_out_byte  = r_out_byte;
        n_pstart    = r_pstart;
        n_fend      = r_fend;
        o_pop       = 1'b0;
        if (w_step) begin
            n_busy      = 1'b1;
            n_frame     = w_frame;
            n_pkt       = w_pkt;
            n_crc       = w_crc;
            n_out_valid = 1'b1;
            n_pstart    = 1'b0;
            n_fend      = 1'b0;
            if (w_pkt == '0) begin
                // packet header ahead of the next frame byte
                unique case (r_hdr)
                    HDR_TYPE: begin
                        n_out_byte = i_pkt_type;
                        n_pstart   = 1'b1;
                        n_hdr      = HDR_LEN;
                    end
                    HDR_LEN: begin
                        n_out_byte = w_hdr_len;
                        n_hdr      = HDR_CHECK;
                    end
                    HDR_CHECK: begin
                        n_out_byte = i_pkt_type ^ w_hdr_len;
                        n_pkt      = w_hdr_len;
                        n_hdr      = HDR_TYPE;
                    end
                    default: begin
                        n_hdr = HDR_TYPE;
                    end
                endcase
            end else begin
                n_out_byte = w_byte;
                n_fend     = (w_frame == 17'd1);
                n_frame    = w_frame - 17'd1;
                n_pkt      = w_pkt - 8'd1;
                if (w_upd) begin
                    n_crc = crc_update(w_crc, w_byte);
                end
                if (r_idx == w_last_idx) begin
                    o_pop  = 1'b1;
                    n_idx  = '0;
                    n_busy = 1'b0;
                end else begin
                    n_idx = r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr       <= HDR_TYPE;
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_frame     <= '0;
            r_pkt       <= '0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_hdr       <= n_hdr;
            r_busy      <= n_busy;
            r_idx       <= n_idx;
            r_frame     <= n_frame;
            r_pkt       <= n_pkt;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
        r_out_byte <= n_out_byte;
        r_pstart   <= n_pstart;
        r_fend     <= n_fend;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.out_byte     = r_out_byte;
    assign o_out.packet_start = r_pstart;
    assign o_out.frame_end    = r_fend;

`ifndef SYNTHESIS
    a_hdr_only_at_packet_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hdr != HDR_TYPE) |-> (r_pkt == '0))
        else $error("header in progress while packet bytes remain");

    a_idle_means_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_idx == '0 && r_hdr == HDR_TYPE))
        else $error("command position left over between commands");

    a_start_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_pstart) |-> !r_fend)
        else $error("header byte marked as frame end");

    a_pop_ends_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_out_valid && !r_pstart))
        else $error("command retired without a frame byte");
`endif

endmodule

`default_nettype wire

>>> rtl/serial_frame_builder_crc16.sv
// ----------------------------------------------------------------------------
// serial_frame_builder_crc16: transmit frame builder with packet cutting
// builds attention and data frames with crc-16 fcs, split into packets
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// i_in      in   valid/ready        action, frame_kind, sequence_req,
//                                   payload_len, data_byte
// o_out     out  valid/ready        out_byte, packet_start, frame_end
// i_cfg     in   write enable only  packet_type_code (8 bit)
//
// input takes one transaction per cycle while the command queue has room
// output sends one line byte per ready cycle; the back sequencer sets the pace
// attention start 5 bytes; data start 8 (5 frame bytes plus a 3-byte header),
// 10 with an empty payload; payload byte 1, 4 with a header, 3 or 6 at the end
// when the queue fills, i_in.ready drops until the back end retires a command
// synchronous active-low reset; type code returns to 22, no frame open
//
`default_nettype none

module serial_frame_builder_crc16 #(
    parameter int unsigned MAX_PACKET_BYTES = sfb_pkg::PKT_MAX_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sfb_in_if.sink           i_in,
    sfb_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [7:0]  i_cfg_wdata
);
    import sfb_pkg::*;

    // configured packet type byte; user writes only while idle, not enforced
    logic [7:0] r_pkt_type;

    // front to queue
    logic       w_push;
    t_cmd       w_push_cmd;
    logic       w_full;

    // queue to back
    logic       w_head_valid;
    t_cmd       w_head_cmd;
    logic       w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_type <= PKT_TYPE_RESET;
        end else if (i_cfg_we) begin
            r_pkt_type <= i_cfg_wdata;
        end
    end

    // front: classify items, drop stray payload bytes, track open payload
    sfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_cmd   (w_push_cmd)
    );

    // queue: decouples input stalls from line-side stalls
    sfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd)
    );

    // back: headers, frame bytes, crc, output register
    sfb_back #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_head_valid),
        .i_cmd      (w_head_cmd),
        .i_pkt_type (r_pkt_type),
        .o_pop      (w_pop),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

>>> tb/frame_byte_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_byte_check_pkg: line byte scoreboard for the serial frame builder
// predicts the packetized frame bytes of every input transaction and checks
// the bytes that leave the block in order
// ----------------------------------------------------------------------------

package frame_byte_check_pkg;

    import sfb_pkg::*;

    localparam int unsigned PKT_LIMIT = PKT_MAX_DEFAULT;
    localparam logic [15:0] FCS_SEED  = 16'hFFFF;
    localparam logic [15:0] FCS_POLY  = 16'h8408;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       packet_start;
        logic       frame_end;
    } t_line_byte;

    class frame_byte_scoreboard;
        t_line_byte  expected_bytes[$];
        int unsigned error_count;
        logic [7:0]  type_code;
        logic        frame_open;
        logic [15:0] payload_left;
        logic [16:0] frame_left;
        logic [7:0]  packet_left;
        logic [15:0] fcs;

        function new();
            error_count = 0;
            type_code   = PKT_TYPE_RESET;
            clear_frame();
        endfunction

        function void clear_frame();
            frame_open   = 1'b0;
            payload_left = '0;
            frame_left   = '0;
            packet_left  = '0;
            fcs          = FCS_SEED;
        endfunction

        function void set_type_code(input logic [7:0] code);
            type_code = code;
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

        // bit-serial form of the reflected fcs, lsb of the byte first
        function logic [15:0] fcs_next(input logic [15:0] acc, input logic [7:0] b);
            logic [15:0] r;
            logic        fb;
            r = acc;
            for (int i = 0; i < 8; i++) begin
                fb = r[0] ^ b[i];
                r  = {1'b0, r[15:1]};
                if (fb) begin
                    r = r ^ FCS_POLY;
                end
            end
            return r;
        endfunction

        // one frame byte, with a packet header in front when a packet opens
        function void emit_frame_byte(input logic [7:0] b);
            logic [16:0] plen;
            if (frame_left == 0) begin
                return;
            end
            if (packet_left == 0) begin
                plen = (frame_left > 17'(PKT_LIMIT)) ? 17'(PKT_LIMIT) : frame_left;
                packet_left = plen[7:0];
                expected_bytes.push_back('{type_code, 1'b1, 1'b0});
                expected_bytes.push_back('{plen[7:0], 1'b0, 1'b0});
                expected_bytes.push_back('{type_code ^ plen[7:0], 1'b0, 1'b0});
            end
            packet_left = packet_left - 8'd1;
            frame_left  = frame_left - 17'd1;
            expected_bytes.push_back('{b, 1'b0, frame_left == 0});
            if (frame_left == 0) begin
                frame_open = 1'b0;
            end
        endfunction

        function void emit_fcs_tail();
            logic [15:0] f;
            f = ~fcs;
            emit_frame_byte(f[7:0]);
            emit_frame_byte(f[15:8]);
        endfunction

        function void note_item(input logic act, input logic [7:0] kind,
                                input logic [7:0] seq, input logic [15:0] len,
                                input logic [7:0] data);
            if (act == ACT_START) begin
                clear_frame();
                if (kind == KIND_ATTN) begin
                    frame_open = 1'b1;
                    frame_left = ATTN_LEN;
                    emit_frame_byte(ATTN_BYTE0);
                    emit_frame_byte(ATTN_BYTE1);
                end else if (kind == KIND_FIRST || kind == KIND_CONT) begin
                    frame_open   = 1'b1;
                    payload_left = len;
                    frame_left   = {1'b0, len} + DATA_OVERHEAD;
                    emit_frame_byte(kind);
                    emit_frame_byte(~kind);
                    emit_frame_byte(seq);
                    emit_frame_byte(len[15:8]);
                    emit_frame_byte(len[7:0]);
                    fcs = fcs_next(fcs, seq);
                    fcs = fcs_next(fcs, len[15:8]);
                    fcs = fcs_next(fcs, len[7:0]);
                    if (payload_left == 0) begin
                        emit_fcs_tail();
                    end
                end
            end else if (frame_open && payload_left != 0) begin
                fcs          = fcs_next(fcs, data);
                payload_left = payload_left - 16'd1;
                emit_frame_byte(data);
                if (payload_left == 0) begin
                    emit_fcs_tail();
                end
            end
        endfunction

        function void check_line_byte(input logic [7:0] b, input logic ps,
                                      input logic fe);
            t_line_byte want;
            if (expected_bytes.size() == 0) begin
                $error("out_byte: expected nothing, got %02h", b);
                error_count++;
                return;
            end
            want = expected_bytes.pop_front();
            if (want.line_byte !== b) begin
                $error("out_byte: expected %02h, got %02h", want.line_byte, b);
                error_count++;
            end
            if (want.packet_start !== ps) begin
                $error("packet_start: expected %0b, got %0b", want.packet_start, ps);
                error_count++;
            end
            if (want.frame_end !== fe) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, fe);
                error_count++;
            end
        endfunction
    endclass

endpackage

>>> tb/serial_frame_builder_crc16_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_frame_builder_crc16_test: self-checking bench of the frame builder
// drives start and payload transactions with random gaps, predicts every
// packetized line byte with crc and headers, and checks the output in order
// across several packet type settings
// ----------------------------------------------------------------------------

module serial_frame_builder_crc16_test;

    import sfb_pkg::*;
    import frame_byte_check_pkg::*;

    // unknown kinds at both ends of the byte range
    localparam logic [7:0] KIND_UNUSED_LO = 8'h00;
    localparam logic [7:0] KIND_UNUSED_HI = 8'hFF;

    // quiet cycles after the last expected byte: covers the command queue
    // draining transactions that make no output
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned TAIL_CYCLES   = 40;

    // one long receiver hold-off so the queue fills and input ready drops
    localparam int unsigned LONG_HOLD_AT     = 150;
    localparam int unsigned LONG_HOLD_CYCLES = 200;

    // no transaction on either side for this long means the block is stuck;
    // the longest legal quiet stretch is the long hold-off plus a settle
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    sfb_in_if  in_ch ();
    sfb_out_if out_ch ();

    frame_byte_scoreboard sb;

    // burst flags: while set, the side does not idle between transactions
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    always #1 clk = ~clk;

    serial_frame_builder_crc16 u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // idle cycles before the next transaction, with occasional burst stretches
    function automatic int unsigned draw_gap(inout bit burst);
        if ($urandom_range(0, 29) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so a back-to-back transaction needs no gap
    task automatic send_item(input logic act, input logic [7:0] kind,
                             input logic [7:0] seq, input logic [15:0] len,
                             input logic [7:0] data);
        int unsigned gap;
        gap = draw_gap(tx_burst);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.action       = act;
        in_ch.frame_kind   = kind;
        in_ch.sequence_req = seq;
        in_ch.payload_len  = len;
        in_ch.data_byte    = data;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(act, kind, seq, len, data);
        @(negedge clk);
    endtask

    // fields the action ignores carry random values
    task automatic send_start(input logic [7:0] kind, input logic [7:0] seq,
                              input logic [15:0] len);
        send_item(ACT_START, kind, seq, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] data);
        send_item(ACT_DATA, 8'($urandom), 8'($urandom), 16'($urandom), data);
    endtask

    // stop offering, wait for every predicted byte, then let the queue settle
    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_type_code(input logic [7:0] code);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = code;
        sb.set_type_code(code);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // mostly complete data frames with random content; some cut short,
    // some with huge lengths, plus attention frames, unknown kinds and
    // stray payload bytes
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned counted;
        int unsigned sel;
        int unsigned deliver;
        logic [15:0] len;
        logic [7:0]  kind;
        counted = 0;
        while (counted < n_items) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                kind = $urandom_range(0, 1) ? KIND_FIRST : KIND_CONT;
                // mostly one packet, sometimes several
                if ($urandom_range(0, 4) == 0) begin
                    len = 16'($urandom_range(41, 100));
                end else begin
                    len = 16'($urandom_range(0, 40));
                end
                deliver = len;
                // broken frame: the next start drops it
                if (sel < 8) begin
                    deliver = $urandom_range(0, len);
                end
                send_start(kind, 8'($urandom), len);
                repeat (deliver) send_payload(8'($urandom));
                counted += deliver + 1;
            end else if (sel < 80) begin
                send_start(KIND_ATTN, 8'($urandom), 16'($urandom));
                counted++;
            end else if (sel < 87) begin
                do kind = 8'($urandom);
                while (kind == KIND_ATTN || kind == KIND_FIRST || kind == KIND_CONT);
                send_start(kind, 8'($urandom), 16'($urandom));
                counted++;
            end else if (sel < 93) begin
                // usually ignored, so not counted
                send_payload(8'($urandom));
            end else begin
                // full 16-bit length, only a few payload bytes before the drop
                len     = 16'($urandom);
                deliver = $urandom_range(0, 12);
                send_start($urandom_range(0, 1) ? KIND_FIRST : KIND_CONT,
                           8'($urandom), len);
                repeat (deliver) send_payload(8'($urandom));
                counted += deliver + 1;
            end
        end
        // close whatever frame is still open before the next setting
        send_start(KIND_ATTN, 8'($urandom), 16'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        sb                 = new();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_START;
        in_ch.frame_kind   = '0;
        in_ch.sequence_req = '0;
        in_ch.payload_len  = '0;
        in_ch.data_byte    = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // directed part, reset type code
        send_start(KIND_ATTN, 8'hFF, 16'hFFFF);
        // empty payload: start sends the whole frame with crc
        send_start(KIND_FIRST, 8'h00, 16'h0000);
        send_start(KIND_CONT, 8'hFF, 16'd3);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_payload(8'h5A);
        // payload byte after the payload is complete
        send_payload(8'h33);
        send_start(KIND_UNUSED_LO, 8'h12, 16'd4);
        send_start(KIND_UNUSED_HI, 8'h34, 16'd0);
        // payload byte with no frame open
        send_payload(8'hC3);
        // start during a frame drops it, longest length
        send_start(KIND_FIRST, 8'h81, 16'hFFFF);
        send_payload(8'hAA);
        send_payload(8'h55);
        send_start(KIND_ATTN, 8'h00, 16'h0000);
        send_start(KIND_FIRST, 8'h7E, 16'h8000);
        send_payload(8'h01);
        send_start(KIND_CONT, 8'h42, 16'd1);
        send_payload(8'h80);

        // random part over several type code settings, extremes first
        write_type_code(8'hFF);
        run_random_phase(60);
        write_type_code(8'h00);
        run_random_phase(60);
        write_type_code(8'($urandom_range(1, 254)));
        run_random_phase(60);

        // catch anything sent after the last expected byte
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (sb.error_count == 0) begin
            $display("serial_frame_builder_crc16_test: clean");
        end else begin
            $display("serial_frame_builder_crc16_test: errors");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: random ready gaps, one long hold-off, in-order checking
    // bytes are captured at the rising edge and checked at the next falling
    // edge, after the sender has noted any transaction of that same edge
    // ------------------------------------------------------------------------
    initial begin : line_receiver
        int unsigned hold;
        int unsigned results_seen;
        logic [7:0]  got_byte;
        logic        got_start;
        logic        got_end;
        results_seen = 0;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            hold = draw_gap(rx_burst);
            if (results_seen == LONG_HOLD_AT) begin
                hold = LONG_HOLD_CYCLES;
            end
            if (hold > 0) begin
                out_ch.ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            do @(posedge clk); while (out_ch.valid !== 1'b1);
            got_byte  = out_ch.out_byte;
            got_start = out_ch.packet_start;
            got_end   = out_ch.frame_end;
            @(negedge clk);
            sb.check_line_byte(got_byte, got_start, got_end);
            results_seen++;
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no transaction on either channel
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("serial_frame_builder_crc16_test: errors");
        $finish;
    end

endmodule
